// File: design/dirf_pkg.sv
// Shared types and codes for the dirty item range finder.
package dirf_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int STATUS_BITS    = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECORD_STRIDE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FULL_RANGE    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OLD_LENGTH    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEW_LENGTH    = 2'd3;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_BYTES = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK,
      STATUS_ZERO_STRIDE,
      STATUS_OLD_MISALIGNED,
      STATUS_NEW_MISALIGNED
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_OLD,
      ST_DIV_NEW
   } state_type;

   typedef struct packed {
      logic done;
      logic exact;
   } div_status_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic activate;
      logic step;
   } trk_ctrl_type;

   typedef struct packed {
      logic emit;
      logic has_range;
      logic last;
   } trk_result_type;

endpackage

// File: design/dirf_div.sv
// Shared restoring divider: one quotient bit per cycle.
module dirf_div #(
   parameter int LENGTH_BITS = 24,
   parameter int STRIDE_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [LENGTH_BITS-1:0]     dividend,
   input  logic [STRIDE_BITS-1:0]     divisor,
   output logic [LENGTH_BITS-1:0]     quotient,
   output dirf_pkg::div_status_type   status
);
   import dirf_pkg::*;

   localparam int CNT_BITS = $clog2(LENGTH_BITS + 1);

   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [LENGTH_BITS-1:0] quo_ff, quo_in;
   logic [STRIDE_BITS-1:0] rem_ff, rem_in;
   logic [STRIDE_BITS-1:0] divisor_ff, divisor_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STRIDE_BITS:0]   trial;
   logic [STRIDE_BITS:0]   diff;
   logic                   fits;

   assign trial = {rem_ff, quo_ff[LENGTH_BITS-1]};
   assign fits  = trial >= {1'b0, divisor_ff};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         count_in   = CNT_BITS'(LENGTH_BITS);
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[LENGTH_BITS-2:0], fits};
         rem_in   = fits ? diff[STRIDE_BITS-1:0] : trial[STRIDE_BITS-1:0];
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign quotient     = quo_ff;
   assign status.done  = done_ff;
   assign status.exact = rem_ff == '0;

endmodule

// File: design/dirf_track.sv
// Record and dirty-run tracker for the byte-pair stream.
module dirf_track #(
   parameter int LENGTH_BITS = 24,
   parameter int STRIDE_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dirf_pkg::trk_ctrl_type     ctrl,
   input  logic [LENGTH_BITS-1:0]     common_load,
   input  logic [LENGTH_BITS-1:0]     total_load,
   input  logic [STRIDE_BITS-1:0]     stride,
   input  logic [7:0]                 old_byte,
   input  logic [7:0]                 new_byte,
   output dirf_pkg::trk_result_type   result,
   output logic [LENGTH_BITS-1:0]     range_offset,
   output logic [LENGTH_BITS-1:0]     range_count
);
   import dirf_pkg::*;

   logic                   active_ff, active_in;
   logic [STRIDE_BITS-1:0] bir_ff, bir_in;
   logic [LENGTH_BITS-1:0] index_ff, index_in;
   logic                   differs_ff, differs_in;
   logic                   open_ff, open_in;
   logic [LENGTH_BITS-1:0] start_ff, start_in;
   logic [LENGTH_BITS-1:0] common_ff, common_in;
   logic [LENGTH_BITS-1:0] total_ff, total_in;

   logic [STRIDE_BITS-1:0] stride_eff;
   logic [STRIDE_BITS:0]   bir_next;
   logic                   differs_now;
   logic                   rec_done;
   logic                   dirty;
   logic                   final_rec;
   logic                   take;

   assign take        = ctrl.step && active_ff;
   assign stride_eff  = (stride == '0) ? STRIDE_BITS'(1) : stride;
   assign bir_next    = {1'b0, bir_ff} + (STRIDE_BITS+1)'(1);
   assign rec_done    = !(bir_next < {1'b0, stride_eff});
   assign differs_now = differs_ff || (old_byte != new_byte);
   assign dirty       = (index_ff >= common_ff) || differs_now;
   assign final_rec   = ({1'b0, index_ff} + (LENGTH_BITS+1)'(1)) >= {1'b0, total_ff};

   always_comb begin
      result.emit      = 1'b0;
      result.has_range = 1'b0;
      result.last      = 1'b0;
      range_offset     = '0;
      range_count      = '0;
      if (take && rec_done) begin
         if (dirty) begin
            if (final_rec) begin
               result.emit      = 1'b1;
               result.has_range = 1'b1;
               result.last      = 1'b1;
               range_offset     = open_ff ? start_ff : index_ff;
               range_count      = total_ff - (open_ff ? start_ff : index_ff);
            end
         end else if (open_ff) begin
            result.emit      = 1'b1;
            result.has_range = 1'b1;
            result.last      = final_rec;
            range_offset     = start_ff;
            range_count      = index_ff - start_ff;
         end else if (final_rec) begin
            result.emit = 1'b1;
            result.last = 1'b1;
         end
      end
   end

   always_comb begin
      active_in  = active_ff;
      bir_in     = bir_ff;
      index_in   = index_ff;
      differs_in = differs_ff;
      open_in    = open_ff;
      start_in   = start_ff;
      common_in  = common_ff;
      total_in   = total_ff;
      if (ctrl.clear) begin
         active_in  = 1'b0;
         bir_in     = '0;
         index_in   = '0;
         differs_in = 1'b0;
         open_in    = 1'b0;
         start_in   = '0;
      end else if (ctrl.load) begin
         common_in = common_load;
         total_in  = total_load;
         active_in = ctrl.activate;
      end else if (take) begin
         if (!rec_done) begin
            bir_in     = bir_next[STRIDE_BITS-1:0];
            differs_in = differs_now;
         end else begin
            bir_in     = '0;
            differs_in = 1'b0;
            index_in   = index_ff + LENGTH_BITS'(1);
            if (dirty) begin
               if (!open_ff) begin
                  open_in  = 1'b1;
                  start_in = index_ff;
               end
            end else begin
               open_in = 1'b0;
            end
            if (final_rec) begin
               active_in = 1'b0;
               index_in  = '0;
               open_in   = 1'b0;
               start_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         bir_ff     <= '0;
         index_ff   <= '0;
         differs_ff <= 1'b0;
         open_ff    <= 1'b0;
         start_ff   <= '0;
         common_ff  <= '0;
         total_ff   <= '0;
      end else begin
         active_ff  <= active_in;
         bir_ff     <= bir_in;
         index_ff   <= index_in;
         differs_ff <= differs_in;
         open_ff    <= open_in;
         start_ff   <= start_in;
         common_ff  <= common_in;
         total_ff   <= total_in;
      end
   end

endmodule

// File: design/dirty_item_range_finder.sv
// Top level of the dirty item range finder: sequencer, registers and result stage.
//
//   channel | ports         | carries
//   --------+---------------+-----------------------------------------------
//   input   | req_*         | start command or one old/new byte pair
//   result  | rsp_*         | status, record counts, one dirty range, last
//   csr     | csr_*         | record_stride, full-range flag, old_length, new_length
//
// A byte pair's result, if any, is in the output register next cycle.
// A start runs the shared divider, which yields one quotient bit per cycle, first for
// old_length, then, if that divides exactly, for new_length; a zero stride skips the divider.
// Reset is synchronous; it empties the output register and ends any job.
// The input stalls while the divider runs and while a held result is stalled.
module dirty_item_range_finder #(
   parameter int  LENGTH_BITS = 24,
   parameter int  STRIDE_BITS = 8,
   localparam int CSR_BITS    = (LENGTH_BITS > STRIDE_BITS) ? LENGTH_BITS : STRIDE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [7:0]                          req_old_byte,
   input  logic [7:0]                          req_new_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dirf_pkg::status_type                rsp_status,
   output logic [LENGTH_BITS-1:0]              rsp_old_records,
   output logic [LENGTH_BITS-1:0]              rsp_new_records,
   output logic                                rsp_has_range,
   output logic [LENGTH_BITS-1:0]              rsp_range_offset,
   output logic [LENGTH_BITS-1:0]              rsp_range_count,
   output logic                                rsp_last,
   input  logic                                csr_write,
   input  logic [dirf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]                 csr_data
);
   import dirf_pkg::*;

   state_type              state_ff, state_in;
   logic [STRIDE_BITS-1:0] stride_ff;
   logic                   force_ff;
   logic [LENGTH_BITS-1:0] old_len_ff;
   logic [LENGTH_BITS-1:0] new_len_ff;
   logic [LENGTH_BITS-1:0] oldr_ff;

   logic                   valid_ff;
   status_type             status_ff, status_in;
   logic [LENGTH_BITS-1:0] old_rec_ff, old_rec_in;
   logic [LENGTH_BITS-1:0] new_rec_ff, new_rec_in;
   logic                   has_ff, has_in;
   logic [LENGTH_BITS-1:0] off_ff, off_in;
   logic [LENGTH_BITS-1:0] cnt_ff, cnt_in;
   logic                   last_ff, last_in;
   logic                   out_load;
   logic                   oldr_load;

   logic                   accept;
   logic                   div_start;
   logic [LENGTH_BITS-1:0] div_dividend;
   logic [LENGTH_BITS-1:0] quotient;
   div_status_type         div_stat;
   trk_ctrl_type           trk_ctrl;
   trk_result_type         trk_res;
   logic [LENGTH_BITS-1:0] trk_off;
   logic [LENGTH_BITS-1:0] trk_cnt;
   logic [LENGTH_BITS-1:0] common_rec;

   assign req_stall  = (state_ff != ST_IDLE) || (valid_ff && rsp_stall);
   assign accept     = req_valid && !req_stall;
   assign common_rec = (oldr_ff < quotient) ? oldr_ff : quotient;

   dirf_div #(
      .LENGTH_BITS(LENGTH_BITS),
      .STRIDE_BITS(STRIDE_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (stride_ff),
      .quotient(quotient),
      .status  (div_stat)
   );

   dirf_track #(
      .LENGTH_BITS(LENGTH_BITS),
      .STRIDE_BITS(STRIDE_BITS)
   ) u_track (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (trk_ctrl),
      .common_load (common_rec),
      .total_load  (quotient),
      .stride      (stride_ff),
      .old_byte    (req_old_byte),
      .new_byte    (req_new_byte),
      .result      (trk_res),
      .range_offset(trk_off),
      .range_count (trk_cnt)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_START && stride_ff != '0) begin
               state_in = ST_DIV_OLD;
            end
         end
         ST_DIV_OLD: begin
            if (div_stat.done) begin
               state_in = div_stat.exact ? ST_DIV_NEW : ST_IDLE;
            end
         end
         ST_DIV_NEW: begin
            if (div_stat.done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      div_start    = 1'b0;
      div_dividend = old_len_ff;
      oldr_load    = 1'b0;
      trk_ctrl     = '0;
      out_load     = 1'b0;
      status_in    = STATUS_OK;
      old_rec_in   = '0;
      new_rec_in   = '0;
      has_in       = 1'b0;
      off_in       = '0;
      cnt_in       = '0;
      last_in      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_START) begin
                  trk_ctrl.clear = 1'b1;
                  if (stride_ff == '0) begin
                     out_load  = 1'b1;
                     status_in = STATUS_ZERO_STRIDE;
                     last_in   = 1'b1;
                  end else begin
                     div_start = 1'b1;
                  end
               end else begin
                  trk_ctrl.step = 1'b1;
                  out_load      = trk_res.emit;
                  has_in        = trk_res.has_range;
                  off_in        = trk_off;
                  cnt_in        = trk_cnt;
                  last_in       = trk_res.last;
               end
            end
         end
         ST_DIV_OLD: begin
            if (div_stat.done) begin
               if (!div_stat.exact) begin
                  out_load  = 1'b1;
                  status_in = STATUS_OLD_MISALIGNED;
                  last_in   = 1'b1;
               end else begin
                  oldr_load    = 1'b1;
                  div_start    = 1'b1;
                  div_dividend = new_len_ff;
               end
            end
         end
         ST_DIV_NEW: begin
            if (div_stat.done) begin
               out_load = 1'b1;
               if (!div_stat.exact) begin
                  status_in = STATUS_NEW_MISALIGNED;
                  last_in   = 1'b1;
               end else begin
                  trk_ctrl.load = 1'b1;
                  old_rec_in    = oldr_ff;
                  new_rec_in    = quotient;
                  if (quotient == '0) begin
                     last_in = 1'b1;
                  end else if (force_ff) begin
                     has_in  = 1'b1;
                     cnt_in  = quotient;
                     last_in = 1'b1;
                  end else begin
                     trk_ctrl.activate = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= 1'b0;
         stride_ff  <= STRIDE_BITS'(1);
         force_ff   <= 1'b0;
         old_len_ff <= '0;
         new_len_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_RECORD_STRIDE: stride_ff  <= csr_data[STRIDE_BITS-1:0];
               CSR_FULL_RANGE:    force_ff   <= csr_data[0];
               CSR_OLD_LENGTH:    old_len_ff <= csr_data[LENGTH_BITS-1:0];
               CSR_NEW_LENGTH:    new_len_ff <= csr_data[LENGTH_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
      if (oldr_load) begin
         oldr_ff <= quotient;
      end
      if (out_load) begin
         status_ff  <= status_in;
         old_rec_ff <= old_rec_in;
         new_rec_ff <= new_rec_in;
         has_ff     <= has_in;
         off_ff     <= off_in;
         cnt_ff     <= cnt_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_old_records  = old_rec_ff;
   assign rsp_new_records  = new_rec_ff;
   assign rsp_has_range    = has_ff;
   assign rsp_range_offset = off_ff;
   assign rsp_range_count  = cnt_ff;
   assign rsp_last         = last_ff;

endmodule

// File: design/dirf_checker.sv
// Port-level assertions for the dirty item range finder, bound to the top level.
module dirf_checker #(
   parameter int  LENGTH_BITS = 24,
   parameter int  STRIDE_BITS = 8,
   localparam int CSR_BITS    = (LENGTH_BITS > STRIDE_BITS) ? LENGTH_BITS : STRIDE_BITS
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_mode,
   input logic [7:0]                          req_old_byte,
   input logic [7:0]                          req_new_byte,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input dirf_pkg::status_type                rsp_status,
   input logic [LENGTH_BITS-1:0]              rsp_old_records,
   input logic [LENGTH_BITS-1:0]              rsp_new_records,
   input logic                                rsp_has_range,
   input logic [LENGTH_BITS-1:0]              rsp_range_offset,
   input logic [LENGTH_BITS-1:0]              rsp_range_count,
   input logic                                rsp_last,
   input logic                                csr_write,
   input logic [dirf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [CSR_BITS-1:0]                 csr_data
);
   import dirf_pkg::*;

   logic unused_inputs;
   assign unused_inputs = ^{req_valid, req_mode, req_old_byte, req_new_byte,
                            rsp_old_records, rsp_new_records, csr_write, csr_index,
                            csr_data};

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_last)
         && $stable(rsp_has_range) && $stable(rsp_range_offset) && $stable(rsp_range_count))
      else $error("stalled result changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input not stalled while result is held");

   a_error_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_last && !rsp_has_range)
      else $error("error result not final or carries a range");

   a_range_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_range |-> rsp_range_count != '0)
      else $error("empty dirty range");

endmodule

bind dirty_item_range_finder dirf_checker #(
   .LENGTH_BITS(LENGTH_BITS),
   .STRIDE_BITS(STRIDE_BITS)
) u_dirf_checker (.*);
